// ===== src/bma_pkg.sv =====
// Package for the boxcar moving-average block: default sizes, the window
// length reset value, queue depth and the command width helper.
// No dependencies; the interfaces, front, back, core and testbench refer to it by scope.
package bma_pkg;

  localparam int MAX_WINDOW  = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int CFG_BITS    = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_BITS-1:0] WINDOW_RESET = 6'd4;

  // Width of one packed command between the front and the back
  function automatic int cmd_bits(input int sample_bits, input int max_window);
    return sample_bits + 2 * $clog2(max_window) + 2 * $clog2(max_window + 1) + 3;
  endfunction

endpackage

// ===== src/bma_if.sv =====
// Channel interfaces of the boxcar moving-average block: sample input,
// result output and window length configuration. Depends on bma_pkg.
interface bma_in_if #(
  parameter int SAMPLE_BITS = bma_pkg::SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          end_of_array;

  modport source (output valid, output sample, output end_of_array, input ready);
  modport sink   (input valid, input sample, input end_of_array, output ready);
endinterface

interface bma_out_if #(
  parameter int SAMPLE_BITS = bma_pkg::SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] average;
  logic                          is_padding;
  logic                          final_result;

  modport source (output valid, output average, output is_padding, output final_result,
                  input ready);
  modport sink   (input valid, input average, input is_padding, input final_result,
                  output ready);
endinterface

interface bma_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bma_pkg::CFG_BITS-1:0]  window_length;

  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface

// ===== src/bma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read during a write to the same address returns the old contents.
module bma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bma_queue.sv =====
// Short command queue between the front and the back of the averager.
// Depends on nothing but its parameters.
module bma_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntBits = $clog2(DEPTH + 1);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(DEPTH - 1);

  logic [WIDTH-1:0]   mem_q [DEPTH];
  logic [PtrBits-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntBits-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntBits'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("command queue pushed while full");

endmodule

// ===== src/bma_front.sv =====
// Front of the averager: holds the window length register, tracks the
// write pointer and fill count, and turns each sample into a command.
// Depends on bma_pkg.
module bma_front #(
  parameter int MAX_WINDOW  = bma_pkg::MAX_WINDOW,
  parameter int SAMPLE_BITS = bma_pkg::SAMPLE_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bma_pkg::CFG_BITS-1:0]         cfg_data_i,
  input  logic                                 in_valid_i,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_i,
  input  logic                                 in_last_i,
  output logic                                 in_ready_o,
  input  logic                                 full_i,
  output logic                                 push_o,
  output logic [bma_pkg::cmd_bits(SAMPLE_BITS, MAX_WINDOW)-1:0] cmd_o
);

  localparam int PB = $clog2(MAX_WINDOW);
  localparam int WB = $clog2(MAX_WINDOW + 1);
  localparam int AB = WB + 1;
  localparam logic [6:0]    MaxW    = 7'(MAX_WINDOW);
  localparam logic [AB-1:0] MaxE    = AB'(MAX_WINDOW);
  localparam logic [PB-1:0] LastPtr = PB'(MAX_WINDOW - 1);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [PB-1:0]                 wr_addr;
    logic [PB-1:0]                 rd_addr;
    logic [WB-1:0]                 win;
    logic [WB-1:0]                 pads;
    logic                          sub;
    logic                          mean;
    logic                          last;
  } cmd_t;

  logic [bma_pkg::CFG_BITS-1:0] wl_q;
  logic [PB-1:0]                wp_q;
  logic [WB-1:0]                fill_q;
  logic [6:0]                   eff;
  logic [WB-1:0]                win;
  logic [AB-1:0]                wp_e, win_e, back_e;
  logic [WB-1:0]                fill_new;
  logic                         full_win;
  cmd_t                         cmd;

  // Zero acts as one, anything above the store depth as the depth
  always_comb begin
    if (wl_q == '0) begin
      eff = 7'd1;
    end else if ({1'b0, wl_q} > MaxW) begin
      eff = MaxW;
    end else begin
      eff = {1'b0, wl_q};
    end
  end
  assign win = WB'(eff);

  assign wp_e     = AB'(wp_q);
  assign win_e    = AB'(win);
  assign back_e   = (wp_e >= win_e) ? (wp_e - win_e) : (wp_e + MaxE - win_e);
  assign full_win = (fill_q == win);
  assign fill_new = full_win ? fill_q : fill_q + 1'b1;

  always_comb begin
    cmd.sample  = in_sample_i;
    cmd.wr_addr = wp_q;
    cmd.rd_addr = back_e[PB-1:0];
    cmd.win     = win;
    cmd.sub     = full_win;
    cmd.mean    = (fill_new == win);
    cmd.last    = in_last_i;
    if (!in_last_i) begin
      cmd.pads = '0;
    end else if (fill_new == win) begin
      cmd.pads = win - 1'b1;
    end else begin
      cmd.pads = fill_new;
    end
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  assign cmd_o      = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q   <= bma_pkg::WINDOW_RESET;
      wp_q   <= '0;
      fill_q <= '0;
    end else if (cfg_we_i) begin
      wl_q   <= cfg_data_i;
      wp_q   <= '0;
      fill_q <= '0;
    end else if (push_o) begin
      if (in_last_i) begin
        wp_q   <= '0;
        fill_q <= '0;
      end else begin
        wp_q   <= (wp_q == LastPtr) ? '0 : wp_q + 1'b1;
        fill_q <= fill_new;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= win)
    else $error("fill count above window length");

endmodule

// ===== src/bma_back.sv =====
// Back of the averager: window store, running sum, serial divider and the
// result register. Takes commands from the queue. Depends on bma_pkg, bma_ram.
module bma_back #(
  parameter int MAX_WINDOW  = bma_pkg::MAX_WINDOW,
  parameter int SAMPLE_BITS = bma_pkg::SAMPLE_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 clear_i,
  input  logic                                 empty_i,
  input  logic [bma_pkg::cmd_bits(SAMPLE_BITS, MAX_WINDOW)-1:0] cmd_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]        out_average_o,
  output logic                                 out_padding_o,
  output logic                                 out_final_o
);

  localparam int PB   = $clog2(MAX_WINDOW);
  localparam int WB   = $clog2(MAX_WINDOW + 1);
  localparam int SUMB = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
  localparam int CB   = $clog2(SUMB + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ACC  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MEAN = 3'd3;
  localparam logic [2:0] ST_PAD  = 3'd4;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [PB-1:0]                 wr_addr;
    logic [PB-1:0]                 rd_addr;
    logic [WB-1:0]                 win;
    logic [WB-1:0]                 pads;
    logic                          sub;
    logic                          mean;
    logic                          last;
  } cmd_t;

  cmd_t                          head, cmd_q, cmd_d;
  logic [2:0]                    st_q, st_d;
  logic [WB-1:0]                 pad_q, pad_d;
  logic [CB-1:0]                 cnt_q, cnt_d;
  logic signed [SUMB-1:0]        sum_q, sum_d, sum_new, old_ext, smp_ext;
  logic [SUMB-1:0]               quo_q, quo_d, mag, res;
  logic [WB-1:0]                 rem_q, rem_d;
  logic [WB:0]                   rem_sh, rem_sub;
  logic                          ge;
  logic                          neg_q, neg_d;
  logic                          ov_q, ov_d;
  logic signed [SAMPLE_BITS-1:0] avg_q, avg_d;
  logic                          padf_q, padf_d, fin_q, fin_d;
  logic                          out_free;
  logic                          ram_we;
  logic [SAMPLE_BITS-1:0]        ram_rdata;

  assign head = cmd_i;

  // Every entry read was written earlier in the same stream, so the store
  // needs no clearing after reset.
  bma_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd_q.wr_addr),
    .wdata_i (cmd_q.sample),
    .raddr_i (head.rd_addr),
    .rdata_o (ram_rdata)
  );

  assign ram_we  = (st_q == ST_ACC);
  assign old_ext = cmd_q.sub ? SUMB'($signed(ram_rdata)) : '0;
  assign smp_ext = SUMB'(cmd_q.sample);
  assign sum_new = sum_q - old_ext + smp_ext;
  assign mag     = sum_new[SUMB-1] ? SUMB'(-sum_new) : SUMB'(sum_new);

  assign rem_sh  = {rem_q, quo_q[SUMB-1]};
  assign rem_sub = rem_sh - {1'b0, cmd_q.win};
  assign ge      = (rem_sh >= {1'b0, cmd_q.win});
  assign res     = neg_q ? (~quo_q + SUMB'(1)) : quo_q;

  assign out_free = !ov_q || out_ready_i;
  assign pop_o    = (st_q == ST_IDLE) && !empty_i;

  always_comb begin
    st_d   = st_q;
    pad_d  = pad_q;
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    cmd_d  = cmd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    ov_d   = ov_q;
    avg_d  = avg_q;
    padf_d = padf_q;
    fin_d  = fin_q;

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    case (st_q)
      ST_IDLE: begin
        if (!empty_i) begin
          cmd_d = head;
          st_d  = ST_ACC;
        end
      end
      ST_ACC: begin
        sum_d = cmd_q.last ? '0 : sum_new;
        neg_d = sum_new[SUMB-1];
        quo_d = mag;
        rem_d = '0;
        cnt_d = CB'(SUMB);
        pad_d = cmd_q.pads;
        if (cmd_q.mean) begin
          st_d = ST_DIV;
        end else if (cmd_q.pads != '0) begin
          st_d = ST_PAD;
        end else begin
          st_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        // One quotient bit per cycle, restoring
        rem_d = ge ? rem_sub[WB-1:0] : rem_sh[WB-1:0];
        quo_d = {quo_q[SUMB-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CB'(1)) begin
          st_d = ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (out_free) begin
          ov_d   = 1'b1;
          avg_d  = res[SAMPLE_BITS-1:0];
          padf_d = 1'b0;
          fin_d  = cmd_q.last && (pad_q == '0);
          st_d   = (pad_q != '0) ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD: begin
        if (out_free) begin
          ov_d   = 1'b1;
          avg_d  = '0;
          padf_d = 1'b1;
          fin_d  = (pad_q == WB'(1));
          pad_d  = pad_q - 1'b1;
          if (pad_q == WB'(1)) begin
            st_d = ST_IDLE;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    if (clear_i) begin
      sum_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      pad_q <= '0;
      cnt_q <= '0;
      sum_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      pad_q <= pad_d;
      cnt_q <= cnt_d;
      sum_q <= sum_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    avg_q  <= avg_d;
    padf_q <= padf_d;
    fin_q  <= fin_d;
  end

  assign out_valid_o   = ov_q;
  assign out_average_o = avg_q;
  assign out_padding_o = padf_q;
  assign out_final_o   = fin_q;

  a_pad_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_PAD) |-> (pad_q != '0))
    else $error("padding state with no padding left");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DIV) |-> (cnt_q != '0))
    else $error("divider running with zero step count");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_PAD && out_free) |=> (ov_q && padf_q && avg_q == '0))
    else $error("padding result not loaded as zero");

endmodule

// ===== src/boxcar_moving_average_core.sv =====
// Boxcar moving average over signed fixed-point samples.
// A sample's command waits in the queue until the back is idle, then updates the window
//   store and running sum, runs through the bit-serial divider if it yields a mean, and
//   the mean and any padding results leave through the output register, which waits on ready.
//   The back takes the next command only once it is done with the last one.
// Reset: asynchronous, active low; window length returns to 4, sum and counts clear.
module boxcar_moving_average_core #(
  parameter int MAX_WINDOW  = bma_pkg::MAX_WINDOW,
  parameter int SAMPLE_BITS = bma_pkg::SAMPLE_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bma_in_if.sink    in_ch_i,
  bma_out_if.source out_ch_o,
  bma_cfg_if.sink   cfg_ch_i
);

  localparam int CmdBits = bma_pkg::cmd_bits(SAMPLE_BITS, MAX_WINDOW);

  // Front/back handoff
  logic               push;
  logic               pop;
  logic               full;
  logic               empty;
  logic [CmdBits-1:0] cmd_in;
  logic [CmdBits-1:0] cmd_out;
  logic               cfg_we;

  // Config writes must arrive only while the block is idle (the block does not enforce it), so take them at once.
  assign cfg_ch_i.ready = 1'b1;
  assign cfg_we         = cfg_ch_i.valid;

  // Front: classify each sample against the fill count and window length,
  // and compute the store addresses and the padding count it will need.
  bma_front #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_ch_i.window_length),
    .in_valid_i  (in_ch_i.valid),
    .in_sample_i (in_ch_i.sample),
    .in_last_i   (in_ch_i.end_of_array),
    .in_ready_o  (in_ch_i.ready),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (cmd_in)
  );

  // Hold classified samples while the back divides or drains padding beats.
  bma_queue #(
    .WIDTH (CmdBits),
    .DEPTH (bma_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (cmd_out),
    .empty_o (empty)
  );

  // Back: update the window store and running sum, divide, then emit the
  // mean beat and any padding beats through its output register.
  bma_back #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       (cfg_we),
    .empty_i       (empty),
    .cmd_i         (cmd_out),
    .pop_o         (pop),
    .out_valid_o   (out_ch_o.valid),
    .out_ready_i   (out_ch_o.ready),
    .out_average_o (out_ch_o.average),
    .out_padding_o (out_ch_o.is_padding),
    .out_final_o   (out_ch_o.final_result)
  );

endmodule

// ===== tb/sv/tb_boxcar_moving_average_core.sv =====
`timescale 1ns / 1ps

// Self-checking testbench for boxcar_moving_average_core: a directed table, then random
// arrays under random valid/ready gaps, every result checked against a window predictor or a typed value.
// Depends on bma_pkg and the channel interfaces of bma_if.sv.
module tb_boxcar_moving_average_core;

  localparam int CLK_HALF     = 5;
  // Cycles to hold after the last result: divider latency plus a full padding tail
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 410;

  typedef logic signed [bma_pkg::SAMPLE_BITS-1:0] sample_t;
  typedef logic [bma_pkg::CFG_BITS-1:0]           window_t;

  typedef struct packed {
    sample_t average;
    logic    is_padding;
    logic    final_result;
  } result_t;

  typedef enum logic { ROW_CFG, ROW_SAMPLE } row_kind_e;

  // How a directed row is checked: by the predictor, by a value typed into the table, or not at all
  typedef enum logic [1:0] { CHK_MODEL, CHK_SILENT, CHK_MEAN } check_e;

  typedef struct packed {
    row_kind_e kind;
    window_t   window_length;
    sample_t   sample;
    logic      end_of_array;
    check_e    chk;
    sample_t   average;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bma_in_if  in_ch ();
  bma_out_if out_ch ();
  bma_cfg_if cfg_ch ();

  boxcar_moving_average_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch),
    .cfg_ch_i (cfg_ch)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Directed table. The reset window of 4 covers the first rows; the config rows walk
  // the single-sample window, the zero and over-range lengths, the mid-stream drop and
  // arrays shorter than the window.
  stim_row_t directed_rows [29] = '{
    '{ROW_SAMPLE, 6'd0,  16'sh7FFF, 1'b0, CHK_SILENT, 16'sh0000},
    '{ROW_SAMPLE, 6'd0,  16'sh7FFF, 1'b0, CHK_SILENT, 16'sh0000},
    '{ROW_SAMPLE, 6'd0,  16'sh7FFF, 1'b0, CHK_SILENT, 16'sh0000},
    '{ROW_SAMPLE, 6'd0,  16'sh7FFF, 1'b0, CHK_MEAN,   16'sh7FFF},
    '{ROW_SAMPLE, 6'd0,  16'sh8000, 1'b0, CHK_MODEL,  16'sh0000},
    '{ROW_SAMPLE, 6'd0,  16'sh8000, 1'b0, CHK_MODEL,  16'sh0000},
    '{ROW_SAMPLE, 6'd0,  16'sh8000, 1'b0, CHK_MODEL,  16'sh0000},
    '{ROW_SAMPLE, 6'd0,  16'sh8000, 1'b0, CHK_MEAN,   16'sh8000},
    '{ROW_SAMPLE, 6'd0,  16'sh0001, 1'b1, CHK_MODEL,  16'sh0000},
    '{ROW_CFG,    6'd1,  16'sh0000, 1'b0, CHK_MODEL,  16'sh0000},
    '{ROW_SAMPLE, 6'd0,  16'shFFFF, 1'b0, CHK_MEAN,   16'shFFFF},
    '{ROW_SAMPLE, 6'd0,  16'sh0100, 1'b1, CHK_MODEL,  16'sh0000},
    '{ROW_CFG,    6'd0,  16'sh0000, 1'b0, CHK_MODEL,  16'sh0000},
    '{ROW_SAMPLE, 6'd0,  16'sh8000, 1'b1, CHK_MODEL,  16'sh0000},
    '{ROW_CFG,    6'd3,  16'sh0000, 1'b0, CHK_MODEL,  16'sh0000},
    '{ROW_SAMPLE, 6'd0,  16'sh0005, 1'b0, CHK_SILENT, 16'sh0000},
    '{ROW_SAMPLE, 6'd0,  16'shFFF9, 1'b1, CHK_MODEL,  16'sh0000},
    '{ROW_CFG,    6'd2,  16'sh0000, 1'b0, CHK_MODEL,  16'sh0000},
    '{ROW_SAMPLE, 6'd0,  16'shFFFD, 1'b0, CHK_SILENT, 16'sh0000},
    // -3 / 2 must truncate toward zero
    '{ROW_SAMPLE, 6'd0,  16'sh0000, 1'b0, CHK_MEAN,   16'shFFFF},
    '{ROW_SAMPLE, 6'd0,  16'sh0007, 1'b0, CHK_MODEL,  16'sh0000},
    '{ROW_CFG,    6'd63, 16'sh0000, 1'b0, CHK_MODEL,  16'sh0000},
    '{ROW_SAMPLE, 6'd0,  16'sh0064, 1'b1, CHK_MODEL,  16'sh0000},
    '{ROW_CFG,    6'd33, 16'sh0000, 1'b0, CHK_MODEL,  16'sh0000},
    '{ROW_SAMPLE, 6'd0,  16'sh3039, 1'b1, CHK_MODEL,  16'sh0000},
    '{ROW_CFG,    6'd32, 16'sh0000, 1'b0, CHK_MODEL,  16'sh0000},
    // Partial array, dropped by the next write
    '{ROW_SAMPLE, 6'd0,  16'shCFC7, 1'b0, CHK_SILENT, 16'sh0000},
    '{ROW_CFG,    6'd4,  16'sh0000, 1'b0, CHK_MODEL,  16'sh0000},
    '{ROW_SAMPLE, 6'd0,  16'sh5A5A, 1'b1, CHK_MODEL,  16'sh0000}
  };

  // Predictor state: window store, running sum, write slot, fill level, window register
  int      window_buf [bma_pkg::MAX_WINDOW] = '{default: 0};
  int      window_sum  = 0;
  int      write_slot  = 0;
  int      fill_level  = 0;
  window_t cfg_window  = bma_pkg::WINDOW_RESET;

  result_t step_results [$];
  result_t pending_results [$];
  result_t seen_result;
  result_t due_result;

  int accepted_samples = 0;
  int mismatch_count   = 0;
  bit calm_phase       = 1'b0;

  // Zero acts as one, anything above the store depth as the store depth
  function automatic int active_window();
    if (cfg_window == '0) return 1;
    if (int'(cfg_window) > bma_pkg::MAX_WINDOW) return bma_pkg::MAX_WINDOW;
    return int'(cfg_window);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly full-range values, with the two extremes mixed in
  function automatic sample_t random_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7FFF;
    if (r == 1) return 16'sh8000;
    return sample_t'($urandom);
  endfunction

  task automatic clear_window_stream();
    window_sum = 0;
    write_slot = 0;
    fill_level = 0;
  endtask

  // Advance the window by one sample and collect the results it causes
  task automatic predict_beat(input sample_t s, input logic last);
    int w;
    int npad;
    w = active_window();
    step_results.delete();
    // Retire the oldest sample once the window is full
    if (fill_level >= w) begin
      window_sum -= window_buf[(write_slot + bma_pkg::MAX_WINDOW - w) % bma_pkg::MAX_WINDOW];
    end
    window_buf[write_slot] = s;
    window_sum += s;
    write_slot = (write_slot + 1) % bma_pkg::MAX_WINDOW;
    if (fill_level < w) fill_level++;
    if (fill_level == w) begin
      npad = last ? w - 1 : 0;
      step_results.push_back('{sample_t'(window_sum / w), 1'b0, last && npad == 0});
    end else begin
      npad = last ? fill_level : 0;
    end
    // Pad the tail so the array yields one result per sample
    for (int p = 0; p < npad; p++) step_results.push_back('{sample_t'(0), 1'b1, p == npad - 1});
    if (last) clear_window_stream();
  endtask

  // Drive one sample beat after a random gap, or none in a calm phase, and record what it should produce
  task automatic send_sample(input sample_t s, input logic last, input check_e chk,
                             input sample_t typed_avg);
    int gap;
    gap = calm_phase ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample       <= s;
    in_ch.end_of_array <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    accepted_samples++;
    predict_beat(s, last);
    case (chk)
      CHK_MODEL: foreach (step_results[i]) pending_results.push_back(step_results[i]);
      CHK_MEAN:  pending_results.push_back('{typed_avg, 1'b0, 1'b0});
      default: ;
    endcase
  endtask

  // Drop valid, wait for every expected result, then let the divider settle
  task automatic drain_results();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the window register only once the block has gone idle
  task automatic write_window(input window_t wl);
    drain_results();
    @(negedge clk_i);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.window_length <= wl;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_window = wl;
    clear_window_stream();
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Result sink: stall at random, with occasional long stretches of steady ready
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = pick_gap();
      @(negedge clk_i);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 80)) @(negedge clk_i);
      else repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  end

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      seen_result = '{out_ch.average, out_ch.is_padding, out_ch.final_result};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: average=%0d is_padding=%0b final_result=%0b",
                 $time, seen_result.average, seen_result.is_padding,
                 seen_result.final_result);
        mismatch_count++;
      end else begin
        due_result = pending_results.pop_front();
        if (seen_result.average !== due_result.average ||
            seen_result.is_padding !== due_result.is_padding ||
            seen_result.final_result !== due_result.final_result) begin
          $display("%0t: mismatch: expected average=%0d is_padding=%0b final_result=%0b,",
                   $time, due_result.average, due_result.is_padding,
                   due_result.final_result);
          $display("%0t:           actual   average=%0d is_padding=%0b final_result=%0b",
                   $time, seen_result.average, seen_result.is_padding,
                   seen_result.final_result);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int  r;
    int  w;
    int  n_arrays;
    int  arr_len;
    int  target;
    bit  pressure_done;

    rst_ni               = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.sample         = '0;
    in_ch.end_of_array   = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.window_length = '0;
    pressure_done        = 1'b0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_window(directed_rows[i].window_length);
      end else begin
        send_sample(directed_rows[i].sample, directed_rows[i].end_of_array,
                    directed_rows[i].chk, directed_rows[i].average);
      end
    end

    // Random phases: one window length each, then well-formed arrays with random
    // content, stray early ends, and sometimes a partial array cut off by the next write.
    // Stop sending once the item budget is spent.
    target = accepted_samples + RANDOM_ITEMS;
    while (accepted_samples < target) begin
      r = $urandom_range(0, 19);
      if (r == 0)     write_window('0);
      else if (r == 1) write_window(window_t'($urandom_range(33, 63)));
      else if (r < 5)  write_window(window_t'($urandom_range(16, 32)));
      else             write_window(window_t'($urandom_range(1, 8)));
      calm_phase = ($urandom_range(0, 3) == 0);
      w = active_window();
      n_arrays = $urandom_range(1, 4);
      for (int a = 0; a < n_arrays && accepted_samples < target; a++) begin
        arr_len = $urandom_range(1, 2 * w + 3);
        for (int k = 0; k < arr_len && accepted_samples < target; k++) begin
          send_sample(random_sample(), k == arr_len - 1 || $urandom_range(0, 29) == 0,
                      CHK_MODEL, '0);
        end
        // Hold the sender until the output side has caught up
        if (!pressure_done || $urandom_range(0, 5) == 0) begin
          drain_results();
          pressure_done = 1'b1;
        end
      end
      if (accepted_samples < target && $urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 2 * w)) begin
          if (accepted_samples < target) send_sample(random_sample(), 1'b0, CHK_MODEL, '0);
        end
      end
      calm_phase = 1'b0;
    end

    drain_results();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #30ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
